@@ rtl/core/edc_pkg.sv @@
// Shared types and constants for the Elias delta codec.
package edc_pkg;

   localparam int VAL_W  = 32;
   localparam int CW_W   = 42;
   localparam int LEN_W  = 6;
   localparam int ST_W   = 2;
   localparam int REQ_W  = 40;
   localparam int RSP_W  = 88;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_ZERO     = 2'd1;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [VAL_W-1:0] decoded;
      logic [LEN_W-1:0] code_length;
      logic [CW_W-1:0]  codeword;
   } edc_rsp_type;

endpackage

@@ rtl/core/edc_enc.sv @@
// Combinational Elias delta encoder for one value.
module edc_enc #(
   parameter int VALUE_BITS = 32
) (
   input  logic [edc_pkg::VAL_W-1:0] value,
   output edc_pkg::edc_rsp_type      res
);
   import edc_pkg::*;

   logic [VAL_W-1:0] v;
   logic [LEN_W-1:0] n;
   logic [LEN_W-1:0] l;
   logic [LEN_W-1:0] shift;
   logic [VAL_W-1:0] top;

   always_comb begin
      for (int i = 0; i < VAL_W; i++) begin
         v[i] = (i < VALUE_BITS) ? value[i] : 1'b0;
      end
      n = '0;
      for (int i = 0; i < VAL_W; i++) begin
         if (v[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      l = '0;
      for (int i = 0; i < LEN_W; i++) begin
         if (n[i]) begin
            l = LEN_W'(i + 1);
         end
      end
      shift = n - LEN_W'(1);
      top   = VAL_W'(1) << shift;

      res.decoded = '0;
      if (n == '0) begin
         res.status      = ST_ZERO;
         res.codeword    = '0;
         res.code_length = '0;
      end else begin
         res.status      = ST_OK;
         res.codeword    = (CW_W'(n) << shift) | CW_W'(v ^ top);
         res.code_length = (l << 1) - LEN_W'(2) + n;
      end
   end

endmodule

@@ rtl/core/edc_dec.sv @@
// Serial Elias delta decoder that takes one code bit per step.
module edc_dec #(
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 bit_in,
   output logic                 emit,
   output edc_pkg::edc_rsp_type res
);
   import edc_pkg::*;

   typedef enum logic [1:0] {
      PH_ZEROS = 2'd0,
      PH_LEN   = 2'd1,
      PH_VAL   = 2'd2
   } phase_type;

   phase_type        phase_ff,      phase_in;
   logic [2:0]       zero_count_ff, zero_count_in;
   logic [6:0]       length_acc_ff, length_acc_in;
   logic [VAL_W-1:0] value_acc_ff,  value_acc_in;
   logic [5:0]       bits_left_ff,  bits_left_in;

   logic [2:0]       zc_inc;
   logic [7:0]       zc_pow;
   logic [6:0]       len_next;
   logic [VAL_W-1:0] val_next;
   logic [5:0]       left_dec;

   always_comb begin
      zc_inc   = zero_count_ff + 3'd1;
      zc_pow   = 8'd1 << zc_inc;
      len_next = {length_acc_ff[5:0], bit_in};
      val_next = {value_acc_ff[VAL_W-2:0], bit_in};
      left_dec = bits_left_ff - 6'd1;

      phase_in      = phase_ff;
      zero_count_in = zero_count_ff;
      length_acc_in = length_acc_ff;
      value_acc_in  = value_acc_ff;
      bits_left_in  = bits_left_ff;
      emit          = 1'b0;
      res           = '0;

      unique case (phase_ff)
         PH_LEN: begin
            length_acc_in = len_next;
            bits_left_in  = left_dec;
            if (left_dec == '0) begin
               if (32'(len_next) > 32'(VALUE_BITS)) begin
                  emit       = 1'b1;
                  res.status = ST_OVERFLOW;
               end else begin
                  phase_in     = PH_VAL;
                  bits_left_in = len_next[5:0] - 6'd1;
                  value_acc_in = VAL_W'(1);
               end
            end
         end
         PH_VAL: begin
            value_acc_in = val_next;
            bits_left_in = left_dec;
            if (left_dec == '0) begin
               emit        = 1'b1;
               res.status  = ST_OK;
               res.decoded = val_next;
            end
         end
         default: begin
            if (!bit_in) begin
               zero_count_in = zc_inc;
               phase_in      = PH_ZEROS;
               if (32'(zc_pow) > 32'(VALUE_BITS)) begin
                  emit       = 1'b1;
                  res.status = ST_OVERFLOW;
               end
            end else if (zero_count_ff == '0) begin
               emit        = 1'b1;
               res.status  = ST_OK;
               res.decoded = VAL_W'(1);
            end else begin
               phase_in      = PH_LEN;
               bits_left_in  = {3'd0, zero_count_ff};
               length_acc_in = 7'd1;
            end
         end
      endcase

      if (emit) begin
         phase_in      = PH_ZEROS;
         zero_count_in = '0;
         length_acc_in = 7'd1;
         value_acc_in  = VAL_W'(1);
         bits_left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ZEROS;
         zero_count_ff <= '0;
         length_acc_ff <= 7'd1;
         value_acc_ff  <= VAL_W'(1);
         bits_left_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         zero_count_ff <= zero_count_in;
         length_acc_ff <= length_acc_in;
         value_acc_ff  <= value_acc_in;
         bits_left_ff  <= bits_left_in;
      end
   end

endmodule

@@ rtl/core/elias_delta_codec_top.sv @@
// A request waits in the input register until the response register is free.
// Throughput is one request per cycle unless the receiver stalls, set by the
// input register and the single-pass encoder or one-bit decoder step feeding
// the response register. A decode request that neither completes a value
// nor overflows produces no response. Synchronous reset clears the mode to
// encode, empties both registers and restarts the decoder.
module elias_delta_codec_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0: value[31:0], bit_in[32], zero padding.
   input  logic [edc_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // Fields from bit 0: codeword[41:0], code_length[47:42], decoded[79:48],
   // status[81:80], zero padding.
   output logic [edc_pkg::RSP_W-1:0]  rsp_tdata
);
   import edc_pkg::*;

   logic             mode_ff;
   logic             in_valid_ff, in_valid_in;
   logic [VAL_W-1:0] in_value_ff;
   logic             in_bit_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   edc_rsp_type      rsp_ff;

   logic        out_free;
   logic        advance;
   logic        dec_step;
   logic        dec_emit;
   logic        produce;
   edc_rsp_type enc_res;
   edc_rsp_type dec_res;
   edc_rsp_type sel_res;

   edc_enc #(.VALUE_BITS(VALUE_BITS)) u_enc (
      .value (in_value_ff),
      .res   (enc_res)
   );

   edc_dec #(.VALUE_BITS(VALUE_BITS)) u_dec (
      .clock  (clock),
      .reset  (reset),
      .step   (dec_step),
      .bit_in (in_bit_ff),
      .emit   (dec_emit),
      .res    (dec_res)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      advance    = in_valid_ff && out_free;
      req_tready = !in_valid_ff || out_free;
      dec_step   = advance && (mode_ff == MODE_DECODE);
      produce    = (mode_ff == MODE_ENCODE) || dec_emit;
      sel_res    = (mode_ff == MODE_ENCODE) ? enc_res : dec_res;

      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = out_free ? (advance && produce) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ENCODE;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_value_ff <= req_tdata[VAL_W-1:0];
         in_bit_ff   <= req_tdata[VAL_W];
      end
      if (advance && produce) begin
         rsp_ff <= sel_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(edc_rsp_type)){1'b0}}, rsp_ff};

endmodule

@@ sim/tb.sv @@
// Testbench for the Elias delta codec: table-driven and random requests checked by a predictor.
`timescale 1ns / 100ps

module tb;
   import edc_pkg::*;

   localparam int VALUE_BITS     = 32;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int N_ROWS         = 29;
   localparam edc_rsp_type NO_RSP = '0;

   typedef enum logic [1:0] {
      COUNT_ZEROS,
      TAKE_LENGTH,
      TAKE_VALUE
   } dec_phase_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] value;
      logic        bit_in;
      logic        typed;
      edc_rsp_type rsp;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic              csr_wdata = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   logic              model_mode;
   dec_phase_type     dec_phase;
   logic [2:0]        zero_cnt;
   logic [6:0]        len_acc;
   logic [31:0]       val_acc;
   logic [5:0]        bits_left;

   edc_rsp_type       pending_rsp [$];
   int                mismatches = 0;
   int                requests_sent = 0;
   int                responses_owed = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_requests = 0;
   int                holds_done = 0;

   // Fields of each row from the left: mode, value, bit_in, typed, expected response.
   directed_row_type directed_rows [N_ROWS] = '{
      {MODE_ENCODE, 32'h0000_0000, 1'b1, 1'b1, ST_ZERO, 32'd0, 6'd0, 42'd0},
      {MODE_ENCODE, 32'h0000_0001, 1'b0, 1'b1, ST_OK, 32'd0, 6'd1, 42'd1},
      {MODE_ENCODE, 32'h0000_0002, 1'b1, 1'b1, ST_OK, 32'd0, 6'd4, 42'd4},
      {MODE_ENCODE, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_OK, 32'd0, 6'd42, 42'h10_7FFF_FFFF},
      {MODE_ENCODE, 32'h8000_0000, 1'b1, 1'b0, NO_RSP},
      {MODE_ENCODE, 32'h0001_0000, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hA5A5_A5A5, 1'b1, 1'b1, ST_OK, 32'd1, 6'd0, 42'd0},
      {MODE_DECODE, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h5A5A_5A5A, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h0000_0000, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h1234_5678, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h8765_4321, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hFFFF_0000, 1'b0, 1'b1, ST_OVERFLOW, 32'd0, 6'd0, 42'd0},
      {MODE_DECODE, 32'h0000_FFFF, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h0F0F_0F0F, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hF0F0_F0F0, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h3333_3333, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hCCCC_CCCC, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h6666_6666, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h9999_9999, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h0000_0001, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h8000_0000, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hDEAD_BEEF, 1'b1, 1'b1, ST_OVERFLOW, 32'd0, 6'd0, 42'd0},
      {MODE_DECODE, 32'hBEEF_DEAD, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h0101_0101, 1'b1, 1'b0, NO_RSP},
      {MODE_ENCODE, 32'h0000_0003, 1'b1, 1'b0, NO_RSP},
      {MODE_DECODE, 32'h1010_1010, 1'b0, 1'b0, NO_RSP},
      {MODE_DECODE, 32'hFEDC_BA98, 1'b1, 1'b0, NO_RSP}
   };

   elias_delta_codec_top #(.VALUE_BITS(VALUE_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic edc_rsp_type elias_encode(input logic [31:0] v);
      edc_rsp_type r;
      int n;
      int l;
      r = '0;
      n = 0;
      l = 0;
      if (v == 0) begin
         r.status = ST_ZERO;
         return r;
      end
      for (int i = 0; i < VALUE_BITS; i++) if (v[i]) n = i + 1;
      for (int i = 0; i < 6; i++) if (n[i]) l = i + 1;
      r.codeword = (42'(n) << (n - 1)) | 42'(64'(v) & ((64'd1 << (n - 1)) - 1));
      r.code_length = LEN_W'(2 * l + n - 2);
      r.status = ST_OK;
      return r;
   endfunction

   task automatic restart_decoder();
      dec_phase = COUNT_ZEROS;
      zero_cnt = '0;
      len_acc = 7'd1;
      val_acc = 32'd1;
      bits_left = '0;
   endtask

   task automatic elias_delta_step(input logic [31:0] v, input logic b,
                                   output bit has_rsp, output edc_rsp_type rsp);
      rsp = '0;
      has_rsp = 1'b0;
      if (model_mode == MODE_ENCODE) begin
         rsp = elias_encode(v);
         has_rsp = 1'b1;
      end else begin
         case (dec_phase)
            TAKE_LENGTH: begin
               len_acc = {len_acc[5:0], b};
               bits_left = bits_left - 6'd1;
               if (bits_left == 0) begin
                  if (len_acc > VALUE_BITS) begin
                     restart_decoder();
                     rsp.status = ST_OVERFLOW;
                     has_rsp = 1'b1;
                  end else begin
                     dec_phase = TAKE_VALUE;
                     bits_left = 6'(len_acc - 7'd1);
                     val_acc = 32'd1;
                  end
               end
            end
            TAKE_VALUE: begin
               val_acc = {val_acc[30:0], b};
               bits_left = bits_left - 6'd1;
               if (bits_left == 0) begin
                  rsp.decoded = val_acc;
                  has_rsp = 1'b1;
                  restart_decoder();
               end
            end
            default: begin
               if (!b) begin
                  zero_cnt = zero_cnt + 3'd1;
                  if ((32'd1 << zero_cnt) > VALUE_BITS) begin
                     restart_decoder();
                     rsp.status = ST_OVERFLOW;
                     has_rsp = 1'b1;
                  end
               end else if (zero_cnt == 0) begin
                  restart_decoder();
                  rsp.decoded = 32'd1;
                  has_rsp = 1'b1;
               end else begin
                  dec_phase = TAKE_LENGTH;
                  bits_left = 6'(zero_cnt);
                  len_acc = 7'd1;
               end
            end
         endcase
      end
   endtask

   task automatic send_request(input logic [31:0] v, input logic b, input bit typed,
                               input edc_rsp_type typed_rsp);
      bit has_rsp;
      edc_rsp_type rsp;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_W - VAL_W - 1){1'b0}}, b, v};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      elias_delta_step(v, b, has_rsp, rsp);
      if (typed) begin
         has_rsp = 1'b1;
         rsp = typed_rsp;
      end
      if (has_rsp) begin
         pending_rsp.push_back(rsp);
         responses_owed++;
      end
      requests_sent++;
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_until_drained();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      model_mode = m;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_value();
      int n;
      logic [31:0] v;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
      v = $urandom;
      v = v & 32'((64'd1 << n) - 1);
      v[n-1] = 1'b1;
      return v;
   endfunction

   task automatic send_random_value();
      int pick;
      logic [31:0] v;
      pick = $urandom_range(0, 99);
      if (pick < 4) v = '0;
      else if (pick < 8) v = '1;
      else v = random_value();
      send_request(v, 1'($urandom), 1'b0, NO_RSP);
   endtask

   // Mostly complete codewords; the rest overflows the length, runs too many zeros,
   // or is loose bits that leave the decoder somewhere in the middle of a code.
   task automatic send_random_code();
      int pick;
      int count;
      edc_rsp_type code;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         code = elias_encode(random_value());
         for (int i = int'(code.code_length) - 1; i >= 0; i--)
            send_request($urandom, code.codeword[i], 1'b0, NO_RSP);
      end else if (pick < 82) begin
         repeat (5) send_request($urandom, 1'b0, 1'b0, NO_RSP);
         send_request($urandom, 1'b1, 1'b0, NO_RSP);
         repeat (5) send_request($urandom, 1'($urandom), 1'b0, NO_RSP);
      end else if (pick < 90) begin
         count = $urandom_range(6, 9);
         repeat (count) send_request($urandom, 1'b0, 1'b0, NO_RSP);
      end else begin
         count = $urandom_range(1, 6);
         repeat (count) send_request($urandom, 1'($urandom), 1'b0, NO_RSP);
      end
   endtask

   task automatic run_phase(input logic m, input int idle_pct, input int stall_pct,
                            input int n_items, input int min_rsp);
      int first_item;
      int first_rsp;
      if (m != model_mode) write_mode(m);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item = requests_sent;
      first_rsp = responses_owed;
      while (requests_sent - first_item < n_items || responses_owed - first_rsp < min_rsp) begin
         if (m == MODE_ENCODE) send_random_value();
         else send_random_code();
      end
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   always @(negedge clock) begin
      edc_rsp_type got;
      edc_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = edc_rsp_type'(rsp_tdata[$bits(edc_rsp_type)-1:0]);
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 64'(got.decoded), 64'd0);
         end else begin
            want = pending_rsp.pop_front();
            if (got.codeword !== want.codeword)
               report_mismatch("codeword", 64'(got.codeword), 64'(want.codeword));
            if (got.code_length !== want.code_length)
               report_mismatch("code_length", 64'(got.code_length), 64'(want.code_length));
            if (got.decoded !== want.decoded)
               report_mismatch("decoded", 64'(got.decoded), 64'(want.decoded));
            if (got.status !== want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
         end
      end
   end

   // The receiver either stalls at random or, when asked, refuses responses for a long stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_done++;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      model_mode = MODE_ENCODE;
      restart_decoder();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         if (directed_rows[i].mode != model_mode) write_mode(directed_rows[i].mode);
         send_request(directed_rows[i].value, directed_rows[i].bit_in,
                      directed_rows[i].typed, directed_rows[i].rsp);
      end

      run_phase(MODE_ENCODE, 0, 0, 80, 0);
      run_phase(MODE_DECODE, 0, 0, 100, 12);
      run_phase(MODE_ENCODE, 47, 0, 60, 0);
      run_phase(MODE_DECODE, 0, 47, 100, 12);
      run_phase(MODE_ENCODE, 25, 25, 60, 0);
      run_phase(MODE_DECODE, 25, 25, 100, 12);

      // Block the response side while requests keep coming, then let everything drain.
      run_phase(MODE_ENCODE, 0, 0, 0, 0);
      hold_requests++;
      repeat (30) send_random_value();
      wait_until_drained();
      run_phase(MODE_DECODE, 47, 47, 50, 6);

      rsp_stall_pct = 0;
      wait_until_drained();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
